// ----- rtl/cvss_pkg.sv -----
// Package for the cell voltage scan statistics unit: word types, register
// indexes, controller states, command/status bundles and sizing constants.
// No dependencies; every other file in rtl/ uses it by scoped names.
package cvss_pkg;

  // Default sizing of the monitor chain
  localparam int MAX_BOARDS         = 5;
  localparam int CHANNELS_PER_BOARD = 12;

  // Fixed register file shape: one mask register per board, one bit per channel
  localparam int MASK_REGS = 5;
  localparam int MASK_BITS = 12;

  // Longest dense cell list
  localparam int MAX_LIST = 60;

  // Field widths
  localparam int BOARD_W   = 3;
  localparam int CHANNEL_W = 4;
  localparam int VOLT_W    = 16;
  localparam int INDEX_W   = 6;
  localparam int TOTAL_W   = 22;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 12;

  // Raw code that marks a missing reading
  localparam logic [VOLT_W-1:0] NO_READING = 16'hFFFF;

  // Register reset values
  localparam logic [BOARD_W-1:0]   BOARD_COUNT_RST = 3'd5;
  localparam logic [MASK_BITS-1:0] MASK_RST        = 12'hFFF;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BOARD_COUNT = 3'd0,
    REG_MASK0       = 3'd1,
    REG_MASK1       = 3'd2,
    REG_MASK2       = 3'd3,
    REG_MASK3       = 3'd4,
    REG_MASK4       = 3'd5
  } cfg_reg_t;

  // Input word: one raw reading
  typedef struct packed {
    logic [BOARD_W-1:0]   board;
    logic [CHANNEL_W-1:0] channel;
    logic [VOLT_W-1:0]    reading;
    logic                 packet_error;
    logic                 scan_end;
  } in_word_t;

  // Output word: one listed cell, statistics on the final one
  typedef struct packed {
    logic [INDEX_W-1:0] cell_index;
    logic [VOLT_W-1:0]  cell_voltage;
    logic [TOTAL_W-1:0] pack_total;
    logic [VOLT_W-1:0]  highest_voltage;
    logic [INDEX_W-1:0] highest_index;
    logic [VOLT_W-1:0]  lowest_voltage;
    logic [INDEX_W-1:0] lowest_index;
    logic               final_cell;
  } out_word_t;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COMMIT,
    ST_COMMIT_END,
    ST_LIST_SCAN,
    ST_LIST_LOAD
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;      // take the input word
    logic clr;         // restart slot walk and list counters
    logic commit_rd;   // read stage at current slot, count listed cell
    logic commit_end;  // drop present bits and error flag, restart walk
    logic step;        // advance to the next slot
    logic rd_held;     // read held voltage at current slot
    logic load;        // load the output register from the held read
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic scan_end;    // scan_end bit of the offered input word
    logic last_slot;   // slot walk is at its last slot
    logic list_done;   // every listed cell has been loaded
    logic cell_en;     // current slot holds an enabled cell
    logic out_free;    // output register can take a word this cycle
  } status_t;

endpackage

// ----- rtl/cell_voltage_scan_statistics_unit.sv -----
// Top level of the cell voltage scan statistics unit: configuration
// registers, controller and datapath. Uses cvss_pkg, cvss_ctrl, cvss_datapath.
//
//   port group | dir | handshake           | word
//   in_        | in  | in_valid / in_stall   | cvss_pkg::in_word_t (one reading)
//   out_       | out | out_valid / out_stall | cvss_pkg::out_word_t (one cell)
//   cfg_       | in  | cfg_we              | cfg_index, cfg_data
//
// A reading without scan_end is only staged. A scan_end word then runs a
// commit sweep (one stage memory read per slot), and a list walk over the
// slots that loads each listed cell into the output register and then
// returns to idle; a stalled output holds the walk.
// Reset is synchronous: present bits, held-entry valid bits and the output
// valid clear at once, so no clearing pass is needed.
module cell_voltage_scan_statistics_unit #(
  parameter int MAX_BOARDS         = cvss_pkg::MAX_BOARDS,
  parameter int CHANNELS_PER_BOARD = cvss_pkg::CHANNELS_PER_BOARD
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  cvss_pkg::in_word_t               in_word,
  output logic                             out_valid,
  input  logic                             out_stall,
  output cvss_pkg::out_word_t              out_word,
  input  logic                             cfg_we,
  input  logic [cvss_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [cvss_pkg::CFG_DAT_W-1:0]   cfg_data
);

  logic [cvss_pkg::BOARD_W-1:0]                            board_count_r;
  logic [cvss_pkg::MASK_REGS-1:0][cvss_pkg::MASK_BITS-1:0] mask_r;
  cvss_pkg::cmd_t                                          cmd;
  cvss_pkg::status_t                                       status;

  // Configuration registers; writes past the last index are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      board_count_r <= cvss_pkg::BOARD_COUNT_RST;
      mask_r        <= {cvss_pkg::MASK_REGS{cvss_pkg::MASK_RST}};
    end else if (cfg_we) begin
      unique case (cvss_pkg::cfg_reg_t'(cfg_index))
        cvss_pkg::REG_BOARD_COUNT: begin
          board_count_r <= cfg_data[cvss_pkg::BOARD_W-1:0];
        end
        cvss_pkg::REG_MASK0, cvss_pkg::REG_MASK1, cvss_pkg::REG_MASK2,
        cvss_pkg::REG_MASK3, cvss_pkg::REG_MASK4: begin
          mask_r[3'(cfg_index - cvss_pkg::CFG_IDX_W'(cvss_pkg::REG_MASK0))] <= cfg_data;
        end
        default: begin
          board_count_r <= board_count_r;
        end
      endcase
    end
  end

  cvss_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  cvss_datapath #(
    .MAX_BOARDS         (MAX_BOARDS),
    .CHANNELS_PER_BOARD (CHANNELS_PER_BOARD)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_word     (in_word),
    .board_count (board_count_r),
    .chan_mask   (mask_r),
    .cmd         (cmd),
    .status      (status),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_word    (out_word)
  );

endmodule

// ----- rtl/cvss_ctrl.sv -----
// Controller for the cell voltage scan statistics unit: sequences staging,
// the commit sweep and the cell list walk. Uses cvss_pkg.
module cvss_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  cvss_pkg::status_t status,
  output cvss_pkg::cmd_t    cmd
);

  cvss_pkg::state_t state_r;
  cvss_pkg::state_t state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cvss_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      cvss_pkg::ST_IDLE: begin
        if (in_valid && status.scan_end) begin
          state_nxt = cvss_pkg::ST_COMMIT;
        end
      end
      cvss_pkg::ST_COMMIT: begin
        if (status.last_slot) begin
          state_nxt = cvss_pkg::ST_COMMIT_END;
        end
      end
      cvss_pkg::ST_COMMIT_END: begin
        state_nxt = cvss_pkg::ST_LIST_SCAN;
      end
      cvss_pkg::ST_LIST_SCAN: begin
        if (status.list_done) begin
          state_nxt = cvss_pkg::ST_IDLE;
        end else if (status.cell_en) begin
          state_nxt = cvss_pkg::ST_LIST_LOAD;
        end
      end
      cvss_pkg::ST_LIST_LOAD: begin
        if (status.out_free) begin
          state_nxt = cvss_pkg::ST_LIST_SCAN;
        end
      end
      default: state_nxt = cvss_pkg::ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state_r)
      cvss_pkg::ST_IDLE: begin
        in_stall   = 1'b0;
        cmd.accept = in_valid;
        cmd.clr    = in_valid && status.scan_end;
      end
      cvss_pkg::ST_COMMIT: begin
        cmd.commit_rd = 1'b1;
        cmd.step      = 1'b1;
      end
      cvss_pkg::ST_COMMIT_END: begin
        cmd.commit_end = 1'b1;
      end
      cvss_pkg::ST_LIST_SCAN: begin
        if (!status.list_done) begin
          cmd.step    = 1'b1;
          cmd.rd_held = status.cell_en;
        end
      end
      cvss_pkg::ST_LIST_LOAD: begin
        cmd.load = status.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

// ----- rtl/cvss_datapath.sv -----
// Datapath for the cell voltage scan statistics unit: stage and held voltage
// memories, slot walk counters, running statistics, output register.
// Uses cvss_pkg; driven by cvss_ctrl commands.
module cvss_datapath #(
  parameter int MAX_BOARDS         = cvss_pkg::MAX_BOARDS,
  parameter int CHANNELS_PER_BOARD = cvss_pkg::CHANNELS_PER_BOARD
) (
  input  logic                                                 clk,
  input  logic                                                 rst_n,
  input  cvss_pkg::in_word_t                                   in_word,
  input  logic [cvss_pkg::BOARD_W-1:0]                         board_count,
  input  logic [cvss_pkg::MASK_REGS-1:0][cvss_pkg::MASK_BITS-1:0] chan_mask,
  input  cvss_pkg::cmd_t                                       cmd,
  output cvss_pkg::status_t                                    status,
  output logic                                                 out_valid,
  input  logic                                                 out_stall,
  output cvss_pkg::out_word_t                                  out_word
);

  localparam int SLOTS  = MAX_BOARDS * CHANNELS_PER_BOARD;
  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int BW     = (MAX_BOARDS > 1) ? $clog2(MAX_BOARDS) : 1;
  localparam int CW     = (CHANNELS_PER_BOARD > 1) ? $clog2(CHANNELS_PER_BOARD) : 1;

  localparam logic [3:0]        NB_LIM    = 4'(MAX_BOARDS);
  localparam logic [4:0]        NC_LIM    = 5'(CHANNELS_PER_BOARD);
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(SLOTS - 1);
  localparam logic [CW-1:0]     CH_LAST   = CW'(CHANNELS_PER_BOARD - 1);
  localparam logic [cvss_pkg::INDEX_W-1:0] LIST_MAX = cvss_pkg::INDEX_W'(cvss_pkg::MAX_LIST);

  // Memories and per-entry flags
  logic [cvss_pkg::VOLT_W-1:0] stage_mem [SLOTS];
  logic [cvss_pkg::VOLT_W-1:0] held_mem  [SLOTS];
  logic [SLOTS-1:0]            pres_r;
  logic [SLOTS-1:0]            hvld_r;
  logic                        err_r;

  // Slot walk
  logic [SLOT_W-1:0] slot_r;
  logic [BW-1:0]     brd_r;
  logic [CW-1:0]     chn_r;

  // Commit pipe
  logic [cvss_pkg::VOLT_W-1:0] st_q_r;
  logic                        cm_wr_r;
  logic [SLOT_W-1:0]           cm_slot_r;

  // Held read
  logic [cvss_pkg::VOLT_W-1:0] hd_q_r;
  logic                        hd_vld_r;

  // List and statistics
  logic [cvss_pkg::INDEX_W-1:0] len_r;
  logic [cvss_pkg::INDEX_W-1:0] n_r;
  logic [cvss_pkg::TOTAL_W-1:0] tot_r;
  logic [cvss_pkg::VOLT_W-1:0]  hi_r;
  logic [cvss_pkg::VOLT_W-1:0]  lo_r;
  logic [cvss_pkg::INDEX_W-1:0] hi_idx_r;
  logic [cvss_pkg::INDEX_W-1:0] lo_idx_r;

  // Output register
  logic                out_valid_r;
  cvss_pkg::out_word_t out_word_r;
  cvss_pkg::out_word_t out_word_nxt;

  logic                         in_ok;
  logic [SLOT_W-1:0]            in_slot;
  logic                         cell_en;
  logic                         brd_listed;
  logic [cvss_pkg::VOLT_W-1:0]  cur_v;
  logic                         first_cell;
  logic                         last_cell;
  logic [cvss_pkg::TOTAL_W-1:0] tot_nxt;
  logic [cvss_pkg::VOLT_W-1:0]  hi_nxt;
  logic [cvss_pkg::VOLT_W-1:0]  lo_nxt;
  logic [cvss_pkg::INDEX_W-1:0] hi_idx_nxt;
  logic [cvss_pkg::INDEX_W-1:0] lo_idx_nxt;
  logic                         out_free;

  // Decode the input word's slot; out-of-range readings are dropped
  always_comb begin
    in_ok   = ({1'b0, in_word.board} < NB_LIM) && ({1'b0, in_word.channel} < NC_LIM);
    in_slot = SLOT_W'(int'(in_word.board) * CHANNELS_PER_BOARD + int'(in_word.channel));
  end

  // Channel enable at the current slot; channels without a mask bit are enabled
  always_comb begin
    if ((int'(brd_r) < cvss_pkg::MASK_REGS) && (int'(chn_r) < cvss_pkg::MASK_BITS)) begin
      cell_en = chan_mask[3'(brd_r)][4'(chn_r)];
    end else begin
      cell_en = 1'b1;
    end
    brd_listed = 3'(brd_r) < board_count;
  end

  // Stage memory, present bits and scan error flag
  always_ff @(posedge clk) begin
    if (cmd.accept && in_ok) begin
      stage_mem[in_slot] <= in_word.reading;
    end
    if (cmd.commit_rd) begin
      st_q_r <= stage_mem[slot_r];
    end
    cm_slot_r <= slot_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pres_r  <= '0;
      err_r   <= 1'b0;
      cm_wr_r <= 1'b0;
    end else begin
      if (cmd.commit_end) begin
        pres_r <= '0;
        err_r  <= 1'b0;
      end else if (cmd.accept) begin
        if (in_ok) begin
          pres_r[in_slot] <= 1'b1;
        end
        if (in_word.packet_error) begin
          err_r <= 1'b1;
        end
      end
      cm_wr_r <= cmd.commit_rd && pres_r[slot_r] && !err_r;
    end
  end

  // Held voltage memory: commit write, list read
  always_ff @(posedge clk) begin
    if (cm_wr_r && (st_q_r != cvss_pkg::NO_READING)) begin
      held_mem[cm_slot_r] <= st_q_r;
    end
    if (cmd.rd_held) begin
      hd_q_r <= held_mem[slot_r];
    end
  end

  // Held entries never written read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hvld_r   <= '0;
      hd_vld_r <= 1'b0;
    end else begin
      if (cm_wr_r && (st_q_r != cvss_pkg::NO_READING)) begin
        hvld_r[cm_slot_r] <= 1'b1;
      end
      if (cmd.rd_held) begin
        hd_vld_r <= hvld_r[slot_r];
      end
    end
  end

  // Slot walk counters and list length
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r <= '0;
      brd_r  <= '0;
      chn_r  <= '0;
      len_r  <= '0;
      n_r    <= '0;
    end else begin
      if (cmd.clr || cmd.commit_end) begin
        slot_r <= '0;
        brd_r  <= '0;
        chn_r  <= '0;
      end else if (cmd.step) begin
        if (slot_r == SLOT_LAST) begin
          slot_r <= '0;
          brd_r  <= '0;
          chn_r  <= '0;
        end else begin
          slot_r <= slot_r + 1'b1;
          if (chn_r == CH_LAST) begin
            chn_r <= '0;
            brd_r <= brd_r + 1'b1;
          end else begin
            chn_r <= chn_r + 1'b1;
          end
        end
      end
      // Count listed cells during the commit sweep
      if (cmd.clr) begin
        len_r <= '0;
      end else if (cmd.commit_rd && cell_en && brd_listed && (len_r != LIST_MAX)) begin
        len_r <= len_r + 1'b1;
      end
      if (cmd.clr || cmd.commit_end) begin
        n_r <= '0;
      end else if (cmd.load) begin
        n_r <= n_r + 1'b1;
      end
    end
  end

  // Running statistics for the cell being loaded
  always_comb begin
    cur_v      = hd_vld_r ? hd_q_r : '0;
    first_cell = (n_r == '0);
    last_cell  = ({1'b0, n_r} + 7'd1) == {1'b0, len_r};
    tot_nxt    = first_cell ? cvss_pkg::TOTAL_W'(cur_v) : tot_r + cvss_pkg::TOTAL_W'(cur_v);
    hi_nxt     = hi_r;
    hi_idx_nxt = hi_idx_r;
    lo_nxt     = lo_r;
    lo_idx_nxt = lo_idx_r;
    if (first_cell || (cur_v > hi_r)) begin
      hi_nxt     = cur_v;
      hi_idx_nxt = n_r;
    end
    if (first_cell || (cur_v < lo_r)) begin
      lo_nxt     = cur_v;
      lo_idx_nxt = n_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      tot_r    <= tot_nxt;
      hi_r     <= hi_nxt;
      lo_r     <= lo_nxt;
      hi_idx_r <= hi_idx_nxt;
      lo_idx_r <= lo_idx_nxt;
    end
  end

  // Output register: hold while stalled, load when free
  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // Build the next word; statistics ride on the last listed cell only
  always_comb begin
    out_word_nxt              = '0;
    out_word_nxt.cell_index   = n_r;
    out_word_nxt.cell_voltage = cur_v;
    if (last_cell) begin
      out_word_nxt.pack_total      = tot_nxt;
      out_word_nxt.highest_voltage = hi_nxt;
      out_word_nxt.highest_index   = hi_idx_nxt;
      out_word_nxt.lowest_voltage  = lo_nxt;
      out_word_nxt.lowest_index    = lo_idx_nxt;
      out_word_nxt.final_cell      = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_word_r <= out_word_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // Status to the controller
  always_comb begin
    status.scan_end  = in_word.scan_end;
    status.last_slot = (slot_r == SLOT_LAST);
    status.list_done = (n_r == len_r);
    status.cell_en   = cell_en;
    status.out_free  = out_free;
  end

endmodule

// ----- rtl/cvss_checker.sv -----
// Port-level checker for the cell voltage scan statistics unit, bound to
// the top level. Uses cvss_pkg word types.
module cvss_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input cvss_pkg::in_word_t  in_word,
  input logic                out_valid,
  input logic                out_stall,
  input cvss_pkg::out_word_t out_word
);

  // A scan end word starts the commit sweep: input held off next cycle
  a_scan_end_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_word.scan_end |=> in_stall)
    else $error("input not held off after scan end");

  // A plain reading only stages: input stays open
  a_stage_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && !in_word.scan_end |=> !in_stall)
    else $error("input held off after plain reading");

  // Non-final words carry no statistics
  a_nonfinal_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_word.final_cell |->
      out_word.pack_total == '0 && out_word.highest_voltage == '0 &&
      out_word.lowest_voltage == '0 && out_word.highest_index == '0 &&
      out_word.lowest_index == '0)
    else $error("statistics on non-final word");

  // Final word: extremes ordered and their indexes within the list
  a_final_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.final_cell |->
      out_word.lowest_voltage <= out_word.highest_voltage &&
      out_word.highest_index <= out_word.cell_index &&
      out_word.lowest_index <= out_word.cell_index)
    else $error("inconsistent final statistics");

endmodule

bind cell_voltage_scan_statistics_unit cvss_checker u_cvss_checker (.*);

// ----- tb/tb_cell_voltage_scan_statistics_unit.sv -----
// Self-checking testbench for cell_voltage_scan_statistics_unit: drives scans of
// readings, predicts each cell word, and checks the output stream field by field.
// Depends on cvss_pkg and the RTL under rtl/.
module tb_cell_voltage_scan_statistics_unit;

  localparam int SLOTS        = cvss_pkg::MAX_BOARDS * cvss_pkg::CHANNELS_PER_BOARD;
  localparam int DRAIN_CYCLES = 200;
  localparam int HOLD_CYCLES  = 300;
  localparam int RAND_ITEMS   = 200;

  // Register indexes past the last mask register; writes there are ignored
  localparam logic [cvss_pkg::CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
  localparam logic [cvss_pkg::CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;

  logic                           clk       = 1'b0;
  logic                           rst_n     = 1'b0;
  logic                           in_valid  = 1'b0;
  logic                           in_stall;
  cvss_pkg::in_word_t             in_word   = '0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  cvss_pkg::out_word_t            out_word;
  logic                           cfg_we    = 1'b0;
  logic [cvss_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [cvss_pkg::CFG_DAT_W-1:0] cfg_data  = '0;

  // Predicted block state and register copy
  logic [cvss_pkg::VOLT_W-1:0]    stage_code [SLOTS];
  bit                             stage_valid[SLOTS];
  logic [cvss_pkg::VOLT_W-1:0]    held_code  [SLOTS];
  bit                             scan_bad;
  logic [cvss_pkg::BOARD_W-1:0]   board_count_cfg;
  logic [cvss_pkg::MASK_BITS-1:0] mask_cfg   [cvss_pkg::MASK_REGS];

  cvss_pkg::in_word_t  readings_to_send[$];
  cvss_pkg::out_word_t expected_cells[$];

  int errors        = 0;
  int readings_sent = 0;
  int scans_closed  = 0;
  int cells_checked = 0;
  int settings_used = 0;
  int gap_left      = 0;
  int stall_left    = 0;
  int hold_left     = 0;
  int holds_req     = 0;
  int holds_done    = 0;
  bit in_idle_on    = 1'b1;
  bit out_idle_on   = 1'b1;

  cell_voltage_scan_statistics_unit u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_word (out_word),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Stage one reading; at scan end commit, then list the enabled cells
  task automatic take_reading(input cvss_pkg::in_word_t w);
    int        slot;
    int        nb;
    int        n;
    logic [cvss_pkg::TOTAL_W-1:0] total;
    logic [cvss_pkg::VOLT_W-1:0]  hi, lo, v;
    logic [cvss_pkg::INDEX_W-1:0] hi_idx, lo_idx;
    bit        enabled;
    cvss_pkg::out_word_t cell_w;
    cvss_pkg::out_word_t listed[$];
    n = 0;
    total = '0;
    hi = '0;
    lo = '0;
    hi_idx = '0;
    lo_idx = '0;
    if (w.board < cvss_pkg::MAX_BOARDS && w.channel < cvss_pkg::CHANNELS_PER_BOARD) begin
      slot = w.board * cvss_pkg::CHANNELS_PER_BOARD + w.channel;
      stage_code[slot] = w.reading;
      stage_valid[slot] = 1'b1;
    end
    if (w.packet_error) scan_bad = 1'b1;
    if (!w.scan_end) return;
    scans_closed++;
    // Commit only a clean scan, and never the missing-reading code
    for (int i = 0; i < SLOTS; i++) begin
      if (!scan_bad && stage_valid[i] && stage_code[i] != cvss_pkg::NO_READING)
        held_code[i] = stage_code[i];
      stage_valid[i] = 1'b0;
    end
    scan_bad = 1'b0;
    nb = (board_count_cfg > cvss_pkg::MAX_BOARDS) ? cvss_pkg::MAX_BOARDS : board_count_cfg;
    for (int b = 0; b < nb; b++) begin
      for (int c = 0; c < cvss_pkg::CHANNELS_PER_BOARD; c++) begin
        enabled = (b < cvss_pkg::MASK_REGS && c < cvss_pkg::MASK_BITS) ? mask_cfg[b][c]
                                                                       : 1'b1;
        if (enabled && n < cvss_pkg::MAX_LIST) begin
          v = held_code[b * cvss_pkg::CHANNELS_PER_BOARD + c];
          if (n == 0) begin
            hi = v;
            lo = v;
          end else begin
            if (v > hi) begin
              hi = v;
              hi_idx = cvss_pkg::INDEX_W'(n);
            end
            if (v < lo) begin
              lo = v;
              lo_idx = cvss_pkg::INDEX_W'(n);
            end
          end
          total = total + cvss_pkg::TOTAL_W'(v);
          cell_w = '0;
          cell_w.cell_index = cvss_pkg::INDEX_W'(n);
          cell_w.cell_voltage = v;
          listed.push_back(cell_w);
          n++;
        end
      end
    end
    // Statistics ride on the last listed cell only
    if (n > 0) begin
      listed[n-1].pack_total = total;
      listed[n-1].highest_voltage = hi;
      listed[n-1].highest_index = hi_idx;
      listed[n-1].lowest_voltage = lo;
      listed[n-1].lowest_index = lo_idx;
      listed[n-1].final_cell = 1'b1;
    end
    foreach (listed[i]) expected_cells.push_back(listed[i]);
  endtask

  function automatic int pick_gap(input bit on);
    int r;
    r = $urandom_range(0, 99);
    if (!on || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Sender: offer queued words, hold a stalled word, insert random gaps
  always @(posedge clk) begin
    logic               nv;
    cvss_pkg::in_word_t nw;
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_word <= '0;
    end else begin
      nv = in_valid;
      nw = in_word;
      if (in_valid && !in_stall) begin
        take_reading(in_word);
        readings_sent++;
        nv = 1'b0;
      end
      if (!nv) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (readings_to_send.size() > 0) begin
          nw = readings_to_send.pop_front();
          nv = 1'b1;
          gap_left = pick_gap(in_idle_on);
        end
      end
      in_valid <= nv;
      in_word <= nw;
    end
  end

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] seen);
    if (want !== seen) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, seen);
    end
  endtask

  // Receiver: check each accepted cell word, then decide the next stall
  always @(posedge clk) begin
    cvss_pkg::out_word_t want;
    logic                s;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_cells.size() == 0) begin
          errors++;
          $display("%0t: cell word with nothing expected, expected none, actual %p",
                   $time, out_word);
        end else begin
          want = expected_cells.pop_front();
          check_field("cell_index", want.cell_index, out_word.cell_index);
          check_field("cell_voltage", want.cell_voltage, out_word.cell_voltage);
          check_field("pack_total", want.pack_total, out_word.pack_total);
          check_field("highest_voltage", want.highest_voltage, out_word.highest_voltage);
          check_field("highest_index", want.highest_index, out_word.highest_index);
          check_field("lowest_voltage", want.lowest_voltage, out_word.lowest_voltage);
          check_field("lowest_index", want.lowest_index, out_word.lowest_index);
          check_field("final_cell", want.final_cell, out_word.final_cell);
          cells_checked++;
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        s = 1'b1;
      end else if (holds_req != holds_done) begin
        holds_done++;
        hold_left = HOLD_CYCLES - 1;
        s = 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        s = 1'b1;
      end else if (out_idle_on && $urandom_range(0, 99) < 25) begin
        stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40)
                                                 : $urandom_range(0, 2);
        s = 1'b1;
      end else begin
        s = 1'b0;
      end
      out_stall <= s;
    end
  end

  // Wait until every word is sent and answered, then let the block settle
  task automatic wait_idle();
    @(negedge clk);
    while (readings_to_send.size() != 0 || in_valid || expected_cells.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [cvss_pkg::CFG_IDX_W-1:0] idx,
                           input logic [cvss_pkg::CFG_DAT_W-1:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (cvss_pkg::cfg_reg_t'(idx))
      cvss_pkg::REG_BOARD_COUNT: board_count_cfg = value[cvss_pkg::BOARD_W-1:0];
      cvss_pkg::REG_MASK0, cvss_pkg::REG_MASK1, cvss_pkg::REG_MASK2, cvss_pkg::REG_MASK3,
      cvss_pkg::REG_MASK4:
        mask_cfg[int'(idx) - int'(cvss_pkg::REG_MASK0)] = value[cvss_pkg::MASK_BITS-1:0];
      default: ;
    endcase
  endtask

  task automatic cfg_all(input logic [cvss_pkg::BOARD_W-1:0] count,
                         input logic [cvss_pkg::MASK_BITS-1:0] m0,
                         input logic [cvss_pkg::MASK_BITS-1:0] m1,
                         input logic [cvss_pkg::MASK_BITS-1:0] m2,
                         input logic [cvss_pkg::MASK_BITS-1:0] m3,
                         input logic [cvss_pkg::MASK_BITS-1:0] m4);
    cfg_write(cvss_pkg::REG_BOARD_COUNT, cvss_pkg::CFG_DAT_W'(count));
    cfg_write(cvss_pkg::REG_MASK0, m0);
    cfg_write(cvss_pkg::REG_MASK1, m1);
    cfg_write(cvss_pkg::REG_MASK2, m2);
    cfg_write(cvss_pkg::REG_MASK3, m3);
    cfg_write(cvss_pkg::REG_MASK4, m4);
    settings_used++;
  endtask

  function automatic cvss_pkg::in_word_t reading_word(input int b, input int c,
                                                      input int code, input bit perr,
                                                      input bit last);
    cvss_pkg::in_word_t w;
    w.board = cvss_pkg::BOARD_W'(b);
    w.channel = cvss_pkg::CHANNEL_W'(c);
    w.reading = cvss_pkg::VOLT_W'(code);
    w.packet_error = perr;
    w.scan_end = last;
    return w;
  endfunction

  function automatic logic [cvss_pkg::MASK_BITS-1:0] rand_mask();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return '0;
    if (r < 25) return cvss_pkg::MASK_RST;
    return cvss_pkg::MASK_BITS'($urandom_range(0, 4095));
  endfunction

  function automatic cvss_pkg::in_word_t rand_reading(input bit last, input int err_pct);
    int b, c, code, r;
    b = ($urandom_range(0, 99) < 92) ? $urandom_range(0, 4) : $urandom_range(5, 7);
    c = ($urandom_range(0, 99) < 92) ? $urandom_range(0, 11) : $urandom_range(12, 15);
    r = $urandom_range(0, 99);
    if (r < 8) code = cvss_pkg::NO_READING;
    else if (r < 14) code = 0;
    else if (r < 20) code = 16'hFFFE;
    else code = $urandom_range(0, 65535);
    return reading_word(b, c, code, $urandom_range(0, 99) < err_pct, last);
  endfunction

  // Queue one scan; most are clean, some carry packet errors
  task automatic queue_scan(input int len);
    int err_pct;
    err_pct = ($urandom_range(0, 99) < 20) ? 15 : 0;
    for (int i = 0; i < len; i++)
      readings_to_send.push_back(rand_reading(i == len - 1, err_pct));
  endtask

  initial begin
    int rand_items;
    int phase;
    int len;
    for (int i = 0; i < SLOTS; i++) begin
      stage_code[i] = '0;
      stage_valid[i] = 1'b0;
      held_code[i] = '0;
    end
    scan_bad = 1'b0;
    board_count_cfg = cvss_pkg::BOARD_COUNT_RST;
    for (int i = 0; i < cvss_pkg::MASK_REGS; i++) mask_cfg[i] = cvss_pkg::MASK_RST;
    settings_used = 1;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: missing reading only, so all held cells stay zero
    readings_to_send.push_back(reading_word(0, 0, cvss_pkg::NO_READING, 0, 1));
    // Extremes, out-of-range board and channel, commit at scan end
    readings_to_send.push_back(reading_word(4, 11, 16'hFFFE, 0, 0));
    readings_to_send.push_back(reading_word(0, 1, 7, 0, 0));
    readings_to_send.push_back(reading_word(7, 15, 1234, 0, 0));
    readings_to_send.push_back(reading_word(2, 13, 4321, 0, 0));
    readings_to_send.push_back(reading_word(5, 3, 999, 0, 0));
    readings_to_send.push_back(reading_word(1, 5, 100, 0, 1));
    // Packet error mid-scan blocks the commit
    readings_to_send.push_back(reading_word(0, 2, 5000, 1, 0));
    readings_to_send.push_back(reading_word(0, 3, 6000, 0, 1));
    // Discarded word still flags an error and ends the scan
    readings_to_send.push_back(reading_word(6, 14, cvss_pkg::NO_READING, 1, 1));
    // Missing reading keeps the held value
    readings_to_send.push_back(reading_word(4, 11, cvss_pkg::NO_READING, 0, 1));
    // Tie for highest between cell 0 and the last cell
    readings_to_send.push_back(reading_word(0, 0, 16'hFFFE, 0, 1));
    wait_idle();

    // Single-cell lists at both ends of the mask
    cfg_all(1, 12'h001, 0, 0, 0, 0);
    readings_to_send.push_back(reading_word(0, 0, 40000, 0, 1));
    wait_idle();
    cfg_write(cvss_pkg::REG_MASK0, 12'h800);
    readings_to_send.push_back(reading_word(0, 11, 1, 0, 1));
    wait_idle();

    // No boards walked: commit happens but nothing is listed
    cfg_write(cvss_pkg::REG_BOARD_COUNT, 0);
    readings_to_send.push_back(reading_word(0, 0, 5, 0, 1));
    wait_idle();

    // Saturated board count, one board masked off, spare indexes ignored
    cfg_all(7, cvss_pkg::MASK_RST, cvss_pkg::MASK_RST, 0, cvss_pkg::MASK_RST,
            cvss_pkg::MASK_RST);
    cfg_write(CFG_SPARE_A, 0);
    cfg_write(CFG_SPARE_B, 0);
    readings_to_send.push_back(reading_word(3, 0, 2, 0, 1));
    wait_idle();

    // All masks clear: no cells listed
    cfg_all(5, 0, 0, 0, 0, 0);
    readings_to_send.push_back(reading_word(1, 1, 3, 0, 1));
    wait_idle();

    // Random phases: new settings, then a few scans with random content
    rand_items = 0;
    phase = 0;
    while (rand_items < RAND_ITEMS) begin
      if (phase == 1) begin
        // Full list while the receiver holds off, so the input backs up
        cfg_all(5, cvss_pkg::MASK_RST, cvss_pkg::MASK_RST, cvss_pkg::MASK_RST,
                cvss_pkg::MASK_RST, cvss_pkg::MASK_RST);
        in_idle_on = 1'b0;
        @(posedge clk);
        holds_req <= holds_req + 1;
      end else begin
        cfg_all(cvss_pkg::BOARD_W'(($urandom_range(0, 99) < 80) ? $urandom_range(1, 5)
                                                                 : $urandom_range(0, 7)),
                rand_mask(), rand_mask(), rand_mask(), rand_mask(), rand_mask());
        if ($urandom_range(0, 3) == 0)
          cfg_write(cvss_pkg::CFG_IDX_W'(CFG_SPARE_A + $urandom_range(0, 1)),
                    cvss_pkg::CFG_DAT_W'($urandom_range(0, 4095)));
        in_idle_on = ($urandom_range(0, 3) != 0);
        out_idle_on = ($urandom_range(0, 3) != 0);
      end
      @(negedge clk);
      for (int s = $urandom_range(2, 4); s > 0; s--) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 40) : $urandom_range(1, 16);
        queue_scan(len);
        rand_items += len;
      end
      wait_idle();
      phase++;
    end

    if (expected_cells.size() != 0) begin
      errors++;
      $display("%0t: cells never seen, expected %0d, actual 0", $time,
               expected_cells.size());
    end
    $display("Sent %0d readings in %0d scans over %0d register settings;", readings_sent,
             scans_closed, settings_used);
    $display("checked %0d cell words, %0d mismatches.", cells_checked, errors);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #16000000;
    $display("Some tests failed");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/cvss_pkg.sv
rtl/cvss_ctrl.sv
rtl/cvss_datapath.sv
rtl/cell_voltage_scan_statistics_unit.sv
rtl/cvss_checker.sv
tb/tb_cell_voltage_scan_statistics_unit.sv
